>>> hw/rtl/oems_pkg.sv
`default_nettype none

package oems_pkg;

    // Width of each key and value field on the stream ports.
    localparam int FIELD_W = 32;

    // Commands from the main controller to the comparator sequencer.
    typedef struct packed {
        logic start;   // restart the network at its first comparator
        logic next;    // move on to the next comparator position
    } t_seq_ctrl;

    // Status of the comparator sequencer for the current position.
    typedef struct packed {
        logic done;    // every pass of the network is finished
        logic live;    // the current position holds a comparator that must run
    } t_seq_stat;

endpackage

`default_nettype wire

>>> hw/rtl/odd_even_merge_sort_by_key_unit.sv
`default_nettype none
// Batch sorter of key and value pairs with an odd-even merge network.
// Input stream: each beat carries one pair in s_axis_tdata (key in the low 32 bits,
// value in the high 32 bits); s_axis_tlast marks the final pair of a batch.
// Up to MAX_LEN pairs are stored; beats beyond that are dropped and the whole
// batch is then flagged on m_axis_tuser.
// After the last beat the network runs over one dual-read, single-write memory:
// a comparator passes through a scan and a compare state, plus a swap state when
// it exchanges, and each position skipped by the network takes only a scan state.
// The sorted pairs then leave in ascending key order, one beat per cycle while
// m_axis_tready is high, with m_axis_tlast on the final one.
// Input is taken one beat per cycle while loading; s_axis_tready is low from the
// last input beat until the last output beat of the batch is taken.
// A stall on the output simply holds the current beat; nothing is lost.
// Reset empties the batch and clears the overflow flag; the stored pairs need
// no clearing since only entries of the current batch are read.
// Equal keys keep their relative order within a compare-exchange.
module odd_even_merge_sort_by_key_unit
    import oems_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int KEY_WIDTH = 32,
    parameter int VAL_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // in_key [31:0], in_value [63:32]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,   // out_key [31:0], out_value [63:32]
    output logic             m_axis_tlast,
    output logic      [0:0]  m_axis_tuser    // overflow [0]
);

    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int ENTRY_W = KEY_WIDTH + VAL_WIDTH;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SWAP = 3'd3;
    localparam logic [2:0] S_ERD  = 3'd4;
    localparam logic [2:0] S_EOUT = 3'd5;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic              r_ovf;
    logic              n_ovf;
    logic [ADDR_W-1:0] r_out_idx;
    logic [ADDR_W-1:0] n_out_idx;

    logic              w_in_beat;
    logic              w_out_beat;
    logic              w_room;
    logic              w_swap;
    logic              w_out_last;

    logic [KEY_WIDTH-1:0] w_in_key;
    logic [VAL_WIDTH-1:0] w_in_val;
    logic [KEY_WIDTH-1:0] w_key_a;
    logic [KEY_WIDTH-1:0] w_key_b;
    logic [VAL_WIDTH-1:0] w_val_a;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr_a;
    logic [ENTRY_W-1:0] w_rdata_a;
    logic [ENTRY_W-1:0] w_rdata_b;

    t_seq_ctrl          w_seq_ctrl;
    t_seq_stat          w_seq_stat;
    logic [ADDR_W-1:0]  w_lo;
    logic [ADDR_W-1:0]  w_hi;

    // Handshakes and field unpacking.
    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = (r_state == S_EOUT);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_out_beat    = m_axis_tvalid && m_axis_tready;
    assign w_room        = (r_fill < CNT_W'(MAX_LEN));

    assign w_in_key = KEY_WIDTH'(s_axis_tdata[FIELD_W-1:0]);
    assign w_in_val = VAL_WIDTH'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);

    assign w_key_a = w_rdata_a[KEY_WIDTH-1:0];
    assign w_key_b = w_rdata_b[KEY_WIDTH-1:0];
    assign w_val_a = w_rdata_a[ENTRY_W-1:KEY_WIDTH];

    // The shared compare unit: swap when the high key is strictly smaller.
    assign w_swap = (w_key_b < w_key_a);

    // Output beat comes straight from the registered read port.
    assign w_out_last   = ((CNT_W'(r_out_idx) + CNT_W'(1)) == r_fill);
    assign m_axis_tdata = {FIELD_W'(w_val_a), FIELD_W'(w_key_a)};
    assign m_axis_tlast = w_out_last;
    assign m_axis_tuser = r_ovf;

    // Memory write port: loading, then the two halves of an exchange.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_fill[ADDR_W-1:0];
        w_wdata = {w_in_val, w_in_key};
        case (r_state)
            S_LOAD: begin
                w_we = w_in_beat && w_room;
            end
            S_CMP: begin
                w_we    = w_swap;
                w_waddr = w_lo;
                w_wdata = w_rdata_b;
            end
            S_SWAP: begin
                w_we    = 1'b1;
                w_waddr = w_hi;
                w_wdata = w_rdata_a;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Memory read ports: both ends of a comparator, or the next output entry.
    always_comb begin
        w_re      = 1'b0;
        w_raddr_a = w_lo;
        case (r_state)
            S_SCAN: begin
                w_re = w_seq_stat.live && !w_seq_stat.done;
            end
            S_ERD: begin
                w_re      = 1'b1;
                w_raddr_a = r_out_idx;
            end
            S_EOUT: begin
                w_re      = 1'b1;
                w_raddr_a = w_out_beat ? (r_out_idx + ADDR_W'(1)) : r_out_idx;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    // Sequencer commands.
    assign w_seq_ctrl.start = w_in_beat && s_axis_tlast;
    assign w_seq_ctrl.next  = ((r_state == S_SCAN) && !w_seq_stat.done && !w_seq_stat.live)
                           || ((r_state == S_CMP) && !w_swap)
                           || (r_state == S_SWAP);

    // Main controller: load, run the network, emit.
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ovf     = r_ovf;
        n_out_idx = r_out_idx;
        case (r_state)
            S_LOAD: begin
                if (w_in_beat) begin
                    if (w_room) begin
                        n_fill = r_fill + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_seq_stat.done) begin
                    n_state   = S_ERD;
                    n_out_idx = '0;
                end else if (w_seq_stat.live) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = w_swap ? S_SWAP : S_SCAN;
            end
            S_SWAP: begin
                n_state = S_SCAN;
            end
            S_ERD: begin
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (w_out_beat) begin
                    if (w_out_last) begin
                        n_state = S_LOAD;
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_out_idx = r_out_idx + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_fill    <= '0;
            r_ovf     <= 1'b0;
            r_out_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_ovf     <= n_ovf;
            r_out_idx <= n_out_idx;
        end
    end

    oems_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_seq_ctrl),
        .i_n     (r_fill),
        .o_stat  (w_seq_stat),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    oems_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_hi),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

endmodule

`default_nettype wire

>>> hw/rtl/oems_ram.sv
`default_nettype none

module oems_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/oems_seq.sv
`default_nettype none

module oems_seq
    import oems_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_seq_ctrl                        i_ctrl,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]     i_n,
    output t_seq_stat                             o_stat,
    output logic      [$clog2(MAX_LEN)-1:0]       o_lo,
    output logic      [$clog2(MAX_LEN)-1:0]       o_hi
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int SCAN_W = CNT_W + 1;
    localparam int ADDR_W = $clog2(MAX_LEN);

    logic [SCAN_W-1:0] r_p;
    logic [SCAN_W-1:0] r_k;
    logic [SCAN_W-1:0] r_lo;

    logic [SCAN_W-1:0] w_n;
    logic [SCAN_W-1:0] w_hi;
    logic [SCAN_W-1:0] w_blk_mask;
    logic [SCAN_W-1:0] w_inc;
    logic [SCAN_W-1:0] w_step;
    logic              w_want;
    logic              w_bit;

    assign w_n  = SCAN_W'(i_n);
    assign w_hi = r_lo + r_k;

    // Both ends of a comparator must lie in the same block of 2p.
    assign w_blk_mask = ~((r_p << 1) - SCAN_W'(1));

    assign o_stat.done = (r_p >= w_n);
    assign o_stat.live = (w_hi < w_n) && ((r_lo & w_blk_mask) == (w_hi & w_blk_mask));

    // The first pass of each p uses positions with bit k clear, the later passes
    // use positions with bit k set; stepping past a wrong run adds k.
    assign w_inc  = r_lo + SCAN_W'(1);
    assign w_want = (r_k != r_p);
    assign w_bit  = ((w_inc & r_k) != '0);
    assign w_step = (w_bit != w_want) ? (w_inc + r_k) : w_inc;

    assign o_lo = r_lo[ADDR_W-1:0];
    assign o_hi = w_hi[ADDR_W-1:0];

    // Walk p over powers of two, k from p down to 1, and lo across each pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.start) begin
            r_p  <= SCAN_W'(1);
            r_k  <= SCAN_W'(1);
            r_lo <= '0;
        end else if (i_ctrl.next) begin
            if (w_hi >= w_n) begin
                if (r_k != SCAN_W'(1)) begin
                    r_k  <= r_k >> 1;
                    r_lo <= r_k >> 1;
                end else begin
                    r_p  <= r_p << 1;
                    r_k  <= r_p << 1;
                    r_lo <= '0;
                end
            end else begin
                r_lo <= w_step;
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_odd_even_merge_sort_by_key_unit.sv
`timescale 1ns / 1ps

module tb_odd_even_merge_sort_by_key_unit
    import oems_pkg::*;
();

    localparam int STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_PRINTS  = 40;

    // One sorted pair as it should leave the block.
    typedef struct {
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
        logic               last;
        logic               overflow;
    } t_sorted_pair;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;   // in_key [31:0], in_value [63:32]
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;        // out_key [31:0], out_value [63:32]
    logic                 m_axis_tlast;
    logic [0:0]           m_axis_tuser;        // overflow [0]

    // Batch being collected by the predictor.
    logic [FIELD_W-1:0]   batch_key [STORE_DEPTH];
    logic [FIELD_W-1:0]   batch_val [STORE_DEPTH];
    int                   batch_len = 0;
    bit                   batch_dropped = 1'b0;

    t_sorted_pair         sorted_q [$];
    t_sorted_pair         head_pair;
    int                   error_count = 0;
    int                   cycle_count = 0;
    int                   random_items = 0;

    // Idling controls for the sender and the receiver.
    bit                   idle_on = 1'b0;
    bit                   long_hold_req = 1'b0;
    int                   long_hold_left = 0;
    int                   stall_left = 0;

    odd_even_merge_sort_by_key_unit #(
        .MAX_LEN   (STORE_DEPTH),
        .KEY_WIDTH (FIELD_W),
        .VAL_WIDTH (FIELD_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply the truncated odd-even merge network to the collected batch.
    function automatic void sort_collected_batch();
        int                 n;
        int                 lo;
        int                 hi;
        logic [FIELD_W-1:0] tmp_key;
        logic [FIELD_W-1:0] tmp_val;
        n = batch_len;
        for (int p = 1; p < n; p <<= 1) begin
            for (int k = p; k >= 1; k >>= 1) begin
                for (int j = (k == p) ? 0 : k; j + k < n; j += 2 * k) begin
                    for (int i = 0; i < k && i + j + k < n; i++) begin
                        lo = i + j;
                        hi = lo + k;
                        // Comparators that straddle two 2p blocks are left out.
                        if (lo / (2 * p) == hi / (2 * p) && batch_key[hi] < batch_key[lo]) begin
                            tmp_key = batch_key[lo];
                            tmp_val = batch_val[lo];
                            batch_key[lo] = batch_key[hi];
                            batch_val[lo] = batch_val[hi];
                            batch_key[hi] = tmp_key;
                            batch_val[hi] = tmp_val;
                        end
                    end
                end
            end
        end
    endfunction

    // Take one accepted beat into the batch; on the last beat, queue the sorted pairs.
    function automatic void collect_pair(logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] value,
                                         logic last);
        t_sorted_pair pair;
        if (batch_len < STORE_DEPTH) begin
            batch_key[batch_len] = key;
            batch_val[batch_len] = value;
            batch_len++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (last) begin
            sort_collected_batch();
            for (int r = 0; r < batch_len; r++) begin
                pair.key      = batch_key[r];
                pair.value    = batch_val[r];
                pair.last     = (r + 1 == batch_len);
                pair.overflow = batch_dropped;
                sorted_q.push_back(pair);
            end
            batch_len     = 0;
            batch_dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                   logic [FIELD_W-1:0] want);
        if (error_count < MAX_PRINTS) begin
            $display("%0d ns: %s: got %h, expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    // Offer one beat, possibly after an idle burst, and wait until it is taken.
    task automatic send_beat(logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] value, logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        collect_pair(key, value, last);
    endtask

    function automatic logic [FIELD_W-1:0] pick_key(bit narrow);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end else if (narrow) begin
            return FIELD_W'($urandom_range(0, 7));
        end
        return FIELD_W'($urandom);
    endfunction

    task automatic send_batch(int len, bit narrow);
        for (int i = 0; i < len; i++) begin
            send_beat(pick_key(narrow), FIELD_W'($urandom), i == len - 1);
        end
    endtask

    // Hold the sender until every queued result has left the block.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Batches of one pair pass unchanged.
    task automatic test_single_pairs();
        send_beat('0, '0, 1'b1);
        send_beat('1, '1, 1'b1);
        send_beat(32'h8000_0001, 32'h1234_5678, 1'b1);
        wait_drained();
    endtask

    // Two-pair batches in order, out of order and with tied keys.
    task automatic test_two_pairs();
        send_beat(32'h0000_0001, 32'hA0A0_0001, 1'b0);
        send_beat(32'h0000_0002, 32'hA0A0_0002, 1'b1);
        send_beat('1, 32'hB0B0_0001, 1'b0);
        send_beat('0, 32'hB0B0_0002, 1'b1);
        send_beat(32'h0000_0042, 32'hC0C0_0001, 1'b0);
        send_beat(32'h0000_0042, 32'hC0C0_0002, 1'b1);
        wait_drained();
    endtask

    // Extreme keys, alternating bit patterns and ties in one batch.
    task automatic test_extreme_keys();
        send_beat('1, 32'h5555_5555, 1'b0);
        send_beat(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_beat('0, '1, 1'b0);
        send_beat(32'hAAAA_AAAA, '0, 1'b0);
        send_beat('1, 32'h0000_0005, 1'b0);
        send_beat(32'h5555_5555, 32'h0000_0006, 1'b0);
        send_beat('0, 32'h0000_0007, 1'b0);
        send_beat(32'h7FFF_FFFF, 32'h0000_0008, 1'b1);
        wait_drained();
    endtask

    // Odd-length descending batch exercises the truncated network.
    task automatic test_descending_batch();
        for (int i = 0; i < 7; i++) begin
            send_beat(FIELD_W'(700 - 100 * i), FIELD_W'(i), i == 6);
        end
        wait_drained();
    endtask

    // Exactly a full store, with no overflow.
    task automatic test_full_batch();
        send_batch(STORE_DEPTH, 1'b0);
        wait_drained();
    endtask

    // Pairs past the store size are dropped, the last beat among them.
    task automatic test_overflow_batch();
        send_batch(STORE_DEPTH + 3, 1'b1);
        wait_drained();
    endtask

    // Output held off for a long stretch while the next batch waits at the input.
    task automatic test_output_hold();
        long_hold_req = 1'b1;
        send_batch(10, 1'b1);
        send_batch(10, 1'b0);
        wait_drained();
    endtask

    // The sender waits for a full drain between two batches.
    task automatic test_drain_pause();
        send_batch(5, 1'b0);
        wait_drained();
        repeat ($urandom_range(1, 11)) @(posedge i_clk);
        send_batch(5, 1'b1);
        wait_drained();
    endtask

    // Random batches, mostly short, some full or overflowing; no idling at the end.
    task automatic test_random_batches();
        int len;
        int pick;
        while (random_items < 65) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                len = $urandom_range(1, 12);
            end else if (pick < 18) begin
                len = $urandom_range(13, 40);
            end else if (pick == 18) begin
                len = STORE_DEPTH;
            end else begin
                len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
            end
            idle_on = (random_items < 45) ? ($urandom_range(0, 3) != 0) : 1'b0;
            send_batch(len, 1'($urandom_range(0, 1)));
            random_items += len;
        end
        wait_drained();
    endtask

    // Output ready: long hold on request, random stall bursts while idling is on.
    always @(posedge i_clk) begin
        if (long_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            long_hold_left--;
        end else if (long_hold_req) begin
            long_hold_req  = 1'b0;
            long_hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare every output beat with the oldest expected pair; guard the run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_odd_even_merge_sort_by_key_unit failed");
            $finish;
        end else if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sorted_q.size() == 0) begin
                report_mismatch("output beat with nothing expected", m_axis_tdata[31:0], '0);
            end else begin
                head_pair = sorted_q.pop_front();
                if (m_axis_tdata[31:0] !== head_pair.key) begin
                    report_mismatch("key", m_axis_tdata[31:0], head_pair.key);
                end
                if (m_axis_tdata[63:32] !== head_pair.value) begin
                    report_mismatch("value", m_axis_tdata[63:32], head_pair.value);
                end
                if (m_axis_tlast !== head_pair.last) begin
                    report_mismatch("last", FIELD_W'(m_axis_tlast), FIELD_W'(head_pair.last));
                end
                if (m_axis_tuser[0] !== head_pair.overflow) begin
                    report_mismatch("overflow", FIELD_W'(m_axis_tuser[0]),
                                    FIELD_W'(head_pair.overflow));
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        test_single_pairs();
        test_two_pairs();
        test_extreme_keys();
        idle_on = 1'b0;
        test_descending_batch();
        idle_on = 1'b1;
        test_full_batch();
        test_overflow_batch();
        test_output_hold();
        test_drain_pause();
        test_random_batches();

        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_odd_even_merge_sort_by_key_unit passed");
        end else begin
            $display("tb_odd_even_merge_sort_by_key_unit failed");
        end
        $finish;
    end

endmodule
